// ===== src/spc_pkg.sv =====
// Shared constants and helper functions for the sprite pixel collision block.
package spc_pkg;

	// Input operation codes.
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_TEST  = 1'b1;

	// Mask select codes.
	localparam logic SEL_A = 1'b0;
	localparam logic SEL_B = 1'b1;

	// Configuration port.
	localparam int CFG_W     = 9;
	localparam int CFG_IDX_W = 3;
	localparam int DIM_REG_W = 7;

	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH_A   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_A  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH_B   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_B  = 3'd4;

	// Fixed field widths.
	localparam int ALPHA_W = 8;
	localparam int PIXEL_W = 6;

	// Command queue between front and back.
	localparam int QUEUE_DEPTH = 4;

	// Width of one queued command word for a given mask coordinate width.
	// Layout: is_test, sel, wen, waddr (2*db), walpha, overlap, six db-wide fields.
	function automatic int cmd_width(int db);
		return 3 + 2 * db + ALPHA_W + 1 + 6 * db;
	endfunction

endpackage

// ===== src/spc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module spc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== src/spc_front.sv =====
// Front end: accepts words, classifies them and queues ready-to-run commands.
module spc_front import spc_pkg::*; #(
	parameter int SPRITE_DIM = 64,
	parameter int COORD_BITS = 11,
	parameter int DB         = $clog2(SPRITE_DIM),
	parameter int DIM_W      = $clog2(SPRITE_DIM + 1)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic                           operation,
	input  logic                           sprite_sel,
	input  logic [PIXEL_W-1:0]             pixel_x,
	input  logic [PIXEL_W-1:0]             pixel_y,
	input  logic [ALPHA_W-1:0]             alpha,
	input  logic signed [COORD_BITS-1:0]   pos_a_x,
	input  logic signed [COORD_BITS-1:0]   pos_a_y,
	input  logic signed [COORD_BITS-1:0]   pos_b_x,
	input  logic signed [COORD_BITS-1:0]   pos_b_y,
	input  logic [DIM_W-1:0]               width_a,
	input  logic [DIM_W-1:0]               height_a,
	input  logic [DIM_W-1:0]               width_b,
	input  logic [DIM_W-1:0]               height_b,
	output logic                           q_valid,
	output logic [cmd_width(DB)-1:0]       q_data,
	input  logic                           q_pop
);

	localparam int CW      = COORD_BITS + 2;
	localparam int EW      = (DB > PIXEL_W) ? DB : PIXEL_W;
	localparam int QPW     = $clog2(QUEUE_DEPTH);
	localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
	localparam int ENTRY_W = cmd_width(DB);

	typedef struct packed {
		logic            is_test;
		logic            sel;
		logic            wen;
		logic [2*DB-1:0] waddr;
		logic [ALPHA_W-1:0] walpha;
		logic            overlap;
		logic [DB-1:0]   owm1;
		logic [DB-1:0]   ohm1;
		logic [DB-1:0]   oax;
		logic [DB-1:0]   oay;
		logic [DB-1:0]   obx;
		logic [DB-1:0]   oby;
	} cmd_t;

	logic accept;
	logic [EW-1:0] px_e, py_e;

	// First stage: box edges and write address.
	logic                 v_s1, test_s1, sel_s1, wen_s1;
	logic [2*DB-1:0]      waddr_s1;
	logic [ALPHA_W-1:0]   walpha_s1;
	logic signed [CW-1:0] ax_s1, ay_s1, bx_s1, by_s1;
	logic signed [CW-1:0] ra_s1, rb_s1, ba_s1, bb_s1;

	// Second step: overlap region, pushed straight into the queue.
	logic signed [CW-1:0] l, t, r, b, ow, oh;
	logic signed [CW-1:0] oax, oay, obx, oby;
	cmd_t                 cmd;

	logic [ENTRY_W-1:0] q_mem_q [QUEUE_DEPTH];
	logic [QPW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               push;

	// A slot is reserved for the word sitting in the first stage.
	assign busy   = (int'(count_q) + int'(v_s1)) >= QUEUE_DEPTH;
	assign accept = start && !busy;

	assign px_e = EW'(pixel_x);
	assign py_e = EW'(pixel_y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			test_s1   <= (operation == OP_TEST);
			sel_s1    <= sprite_sel;
			wen_s1    <= (int'(pixel_x) < SPRITE_DIM) && (int'(pixel_y) < SPRITE_DIM);
			waddr_s1  <= {py_e[DB-1:0], px_e[DB-1:0]};
			walpha_s1 <= alpha;
			ax_s1     <= CW'(pos_a_x);
			ay_s1     <= CW'(pos_a_y);
			bx_s1     <= CW'(pos_b_x);
			by_s1     <= CW'(pos_b_y);
			ra_s1     <= CW'(pos_a_x) + CW'($signed({1'b0, width_a}));
			rb_s1     <= CW'(pos_b_x) + CW'($signed({1'b0, width_b}));
			ba_s1     <= CW'(pos_a_y) + CW'($signed({1'b0, height_a}));
			bb_s1     <= CW'(pos_b_y) + CW'($signed({1'b0, height_b}));
		end
	end

	always_comb begin
		l   = (ax_s1 > bx_s1) ? ax_s1 : bx_s1;
		t   = (ay_s1 > by_s1) ? ay_s1 : by_s1;
		r   = (ra_s1 < rb_s1) ? ra_s1 : rb_s1;
		b   = (ba_s1 < bb_s1) ? ba_s1 : bb_s1;
		ow  = r - l;
		oh  = b - t;
		oax = l - ax_s1;
		oay = t - ay_s1;
		obx = l - bx_s1;
		oby = t - by_s1;

		cmd.is_test = test_s1;
		cmd.sel     = sel_s1;
		cmd.wen     = wen_s1;
		cmd.waddr   = waddr_s1;
		cmd.walpha  = walpha_s1;
		cmd.overlap = (ow > 0) && (oh > 0);
		cmd.owm1    = DB'(ow - CW'(1));
		cmd.ohm1    = DB'(oh - CW'(1));
		cmd.oax     = DB'(oax);
		cmd.oay     = DB'(oay);
		cmd.obx     = DB'(obx);
		cmd.oby     = DB'(oby);
	end

	assign push    = v_s1;
	assign q_valid = (count_q != '0);
	assign q_data  = q_mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPW'(1);
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + QPW'(1);
			end
			case ({push, q_pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (int'(count_q) < QUEUE_DEPTH) || q_pop)
		else $error("command queue overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (int'(count_q) + int'(v_s1)) <= QUEUE_DEPTH)
		else $error("accepted word has no reserved queue slot");
`endif

endmodule

// ===== src/spc_back.sv =====
// Back end: runs queued commands, writes the masks and scans overlap regions.
module spc_back import spc_pkg::*; #(
	parameter int SPRITE_DIM = 64,
	parameter int DB         = $clog2(SPRITE_DIM)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_valid,
	input  logic [cmd_width(DB)-1:0]   q_data,
	output logic                       q_pop,
	input  logic signed [CFG_W-1:0]    threshold,
	output logic                       done,
	output logic                       hit,
	output logic                       boxes_overlap
);

	localparam int MASK_DEPTH = 1 << (2 * DB);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SCAN = 1'b1;

	typedef struct packed {
		logic            is_test;
		logic            sel;
		logic            wen;
		logic [2*DB-1:0] waddr;
		logic [ALPHA_W-1:0] walpha;
		logic            overlap;
		logic [DB-1:0]   owm1;
		logic [DB-1:0]   ohm1;
		logic [DB-1:0]   oax;
		logic [DB-1:0]   oay;
		logic [DB-1:0]   obx;
		logic [DB-1:0]   oby;
	} cmd_t;

	cmd_t head;

	logic          state_q;
	logic [DB-1:0] owm1_q, ohm1_q, oax_q, oay_q, obx_q, oby_q;
	logic [DB-1:0] dx_q, dy_q;
	logic          issue_done_q, pend_q, pend_last_q;
	logic          done_q, hit_q, ovl_q;

	logic               we_a, we_b, at_last, a_ok, b_ok;
	logic [DB-1:0]      row_a, col_a, row_b, col_b;
	logic [ALPHA_W-1:0] rdata_a, rdata_b;

	assign head  = cmd_t'(q_data);
	assign q_pop = (state_q == ST_IDLE) && q_valid;

	assign we_a = q_pop && !head.is_test && head.wen && (head.sel == SEL_A);
	assign we_b = q_pop && !head.is_test && head.wen && (head.sel == SEL_B);

	assign row_a = oay_q + dy_q;
	assign col_a = oax_q + dx_q;
	assign row_b = oby_q + dy_q;
	assign col_b = obx_q + dx_q;

	spc_ram #(.WIDTH(ALPHA_W), .DEPTH(MASK_DEPTH)) u_mask_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (head.waddr),
		.wdata (head.walpha),
		.raddr ({row_a, col_a}),
		.rdata (rdata_a)
	);

	spc_ram #(.WIDTH(ALPHA_W), .DEPTH(MASK_DEPTH)) u_mask_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (head.waddr),
		.wdata (head.walpha),
		.raddr ({row_b, col_b}),
		.rdata (rdata_b)
	);

	assign at_last = (dx_q == owm1_q) && (dy_q == ohm1_q);
	assign a_ok    = $signed({1'b0, rdata_a}) > threshold;
	assign b_ok    = $signed({1'b0, rdata_b}) > threshold;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			done_q       <= 1'b0;
			issue_done_q <= 1'b0;
			pend_q       <= 1'b0;
			pend_last_q  <= 1'b0;
			dx_q         <= '0;
			dy_q         <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (q_pop && head.is_test) begin
						if (!head.overlap || threshold[CFG_W-1]) begin
							done_q <= 1'b1;
						end else begin
							state_q      <= ST_SCAN;
							dx_q         <= '0;
							dy_q         <= '0;
							issue_done_q <= 1'b0;
							pend_q       <= 1'b0;
							pend_last_q  <= 1'b0;
						end
					end
				end
				ST_SCAN: begin
					pend_q      <= !issue_done_q;
					pend_last_q <= at_last;
					if (!issue_done_q) begin
						if (at_last) begin
							issue_done_q <= 1'b1;
						end else if (dx_q == owm1_q) begin
							dx_q <= '0;
							dy_q <= dy_q + DB'(1);
						end else begin
							dx_q <= dx_q + DB'(1);
						end
					end
					if (pend_q && ((a_ok && b_ok) || pend_last_q)) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && head.is_test) begin
			owm1_q <= head.owm1;
			ohm1_q <= head.ohm1;
			oax_q  <= head.oax;
			oay_q  <= head.oay;
			obx_q  <= head.obx;
			oby_q  <= head.oby;
			hit_q  <= head.overlap && threshold[CFG_W-1];
			ovl_q  <= head.overlap;
		end else if (state_q == ST_SCAN && pend_q) begin
			hit_q <= a_ok && b_ok;
		end
	end

	assign done          = done_q;
	assign hit           = hit_q;
	assign boxes_overlap = ovl_q;

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (dy_q <= ohm1_q))
		else $error("scan row counter left the overlap region");
	assert property (@(posedge clk) disable iff (!arst_n)
		(we_a || we_b) |-> (state_q == ST_IDLE) && !(we_a && we_b))
		else $error("mask write outside idle or to both masks");
	assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && $past(state_q) == ST_SCAN) |-> $past(pend_q))
		else $error("scan result without a compared pixel pair");
	assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && hit_q) |-> ovl_q)
		else $error("hit reported without box overlap");
`endif

endmodule

// ===== src/sprite_pixel_collision.sv =====
// Top level of the sprite pixel collision block: configuration registers and wiring.
//
// Usage. A word is accepted at a rising edge where start is high and busy is low.
// Operation selects a mask write (one alpha pixel into sprite A or B) or a
// collision test with the two top-left screen positions. A write produces no
// result; a test produces exactly one result word on hit and boxes_overlap,
// marked by done for a single cycle. The receiver cannot stall, so done is never
// held off.
// A test whose boxes do not overlap, or that runs with a negative threshold, passes
// through the first-stage register and the queue and is answered when the back end
// pops it. A test that scans ends early at the first pixel pair whose alpha exceeds
// the threshold in both masks. The scan reads one pixel pair per cycle from the two
// mask RAMs, and that read port sets the rate. A write is performed as it is popped.
// A four-word command queue sits between front and back, so further words are
// taken while a scan runs; busy rises when the queue, counting the word held in
// the first stage, is full. Configuration is written through cfg_we, cfg_index
// and cfg_wdata while the block is idle; the block itself does not enforce this.
// Reset sets the threshold to 1 and all sprite sizes to 64; mask contents are
// undefined until written.
module sprite_pixel_collision import spc_pkg::*; #(
	parameter int SPRITE_DIM = 64,
	parameter int COORD_BITS = 11
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         operation,
	input  logic                         sprite_sel,
	input  logic [PIXEL_W-1:0]           pixel_x,
	input  logic [PIXEL_W-1:0]           pixel_y,
	input  logic [ALPHA_W-1:0]           alpha,
	input  logic signed [COORD_BITS-1:0] pos_a_x,
	input  logic signed [COORD_BITS-1:0] pos_a_y,
	input  logic signed [COORD_BITS-1:0] pos_b_x,
	input  logic signed [COORD_BITS-1:0] pos_b_y,
	input  logic                         cfg_we,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_W-1:0]             cfg_wdata,
	output logic                         done,
	output logic                         hit,
	output logic                         boxes_overlap
);

	localparam int DB      = $clog2(SPRITE_DIM);
	localparam int DIM_W   = $clog2(SPRITE_DIM + 1);
	localparam int RST_DIM = (SPRITE_DIM < 64) ? SPRITE_DIM : 64;

	// Sizes are stored already saturated to the mask dimension, so the
	// front end never has to clamp them on the item path.
	function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_REG_W-1:0] v);
		if (int'(v) > SPRITE_DIM) begin
			return DIM_W'(SPRITE_DIM);
		end
		return DIM_W'(v);
	endfunction

	logic signed [CFG_W-1:0] threshold_q;
	logic [DIM_W-1:0]        width_a_q, height_a_q, width_b_q, height_b_q;

	logic                     q_valid, q_pop;
	logic [cmd_width(DB)-1:0] q_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= CFG_W'(1);
			width_a_q   <= DIM_W'(RST_DIM);
			height_a_q  <= DIM_W'(RST_DIM);
			width_b_q   <= DIM_W'(RST_DIM);
			height_b_q  <= DIM_W'(RST_DIM);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_THRESHOLD: threshold_q <= $signed(cfg_wdata);
				REG_WIDTH_A:   width_a_q   <= clamp_dim(cfg_wdata[DIM_REG_W-1:0]);
				REG_HEIGHT_A:  height_a_q  <= clamp_dim(cfg_wdata[DIM_REG_W-1:0]);
				REG_WIDTH_B:   width_b_q   <= clamp_dim(cfg_wdata[DIM_REG_W-1:0]);
				REG_HEIGHT_B:  height_b_q  <= clamp_dim(cfg_wdata[DIM_REG_W-1:0]);
				default: ;
			endcase
		end
	end

	// The front end takes words, computes box edges and the overlap region,
	// and queues one command word per accepted item.
	spc_front #(
		.SPRITE_DIM (SPRITE_DIM),
		.COORD_BITS (COORD_BITS),
		.DB         (DB),
		.DIM_W      (DIM_W)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.operation  (operation),
		.sprite_sel (sprite_sel),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.alpha      (alpha),
		.pos_a_x    (pos_a_x),
		.pos_a_y    (pos_a_y),
		.pos_b_x    (pos_b_x),
		.pos_b_y    (pos_b_y),
		.width_a    (width_a_q),
		.height_a   (height_a_q),
		.width_b    (width_b_q),
		.height_b   (height_b_q),
		.q_valid    (q_valid),
		.q_data     (q_data),
		.q_pop      (q_pop)
	);

	// The back end owns both masks: it performs writes and scans overlap
	// regions one pixel pair per cycle.
	spc_back #(
		.SPRITE_DIM (SPRITE_DIM),
		.DB         (DB)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_data        (q_data),
		.q_pop         (q_pop),
		.threshold     (threshold_q),
		.done          (done),
		.hit           (hit),
		.boxes_overlap (boxes_overlap)
	);

endmodule

// ===== tb/sv/tb_sprite_pixel_collision.sv =====
// Self-checking testbench for the sprite pixel collision block.
`timescale 1ns / 1ps

module tb_sprite_pixel_collision;
	import spc_pkg::*;

	localparam int SPRITE_DIM      = 64;
	localparam int COORD_BITS      = 11;
	localparam int MASK_DEPTH      = SPRITE_DIM * SPRITE_DIM;
	localparam int COORD_MIN       = -(1 << (COORD_BITS - 1));
	localparam int COORD_MAX       = (1 << (COORD_BITS - 1)) - 1;
	localparam int COORD_SPAN      = 1 << COORD_BITS;
	localparam int ALPHA_MAX       = (1 << ALPHA_W) - 1;
	localparam int PIXEL_MAX       = (1 << PIXEL_W) - 1;
	localparam int RESET_CYCLES    = 9;
	localparam int DRAIN_CYCLES    = 32;
	localparam int WATCHDOG_LIMIT  = 50000;
	localparam int PHASES          = 10;
	localparam int WORDS_PER_PHASE = 9;
	localparam int FILL_DIM        = 4;

	// Register indexes past the last real register; writes there must do nothing.
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = REG_HEIGHT_B + 1'b1;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = '1;

	// One command word as it appears on the input ports.
	typedef struct packed {
		logic                         op;
		logic                         sel;
		logic [PIXEL_W-1:0]           px;
		logic [PIXEL_W-1:0]           py;
		logic [ALPHA_W-1:0]           alpha;
		logic signed [COORD_BITS-1:0] ax;
		logic signed [COORD_BITS-1:0] ay;
		logic signed [COORD_BITS-1:0] bx;
		logic signed [COORD_BITS-1:0] by;
	} cmd_word_t;

	// The answer to one collision test.
	typedef struct packed {
		logic hit;
		logic overlap;
	} verdict_t;

	logic                         clk           = 1'b0;
	logic                         arst_n        = 1'b0;
	logic                         start         = 1'b0;
	logic                         operation     = OP_WRITE;
	logic                         sprite_sel    = SEL_A;
	logic [PIXEL_W-1:0]           pixel_x       = '0;
	logic [PIXEL_W-1:0]           pixel_y       = '0;
	logic [ALPHA_W-1:0]           alpha         = '0;
	logic signed [COORD_BITS-1:0] pos_a_x       = '0;
	logic signed [COORD_BITS-1:0] pos_a_y       = '0;
	logic signed [COORD_BITS-1:0] pos_b_x       = '0;
	logic signed [COORD_BITS-1:0] pos_b_y       = '0;
	logic                         cfg_we        = 1'b0;
	logic [CFG_IDX_W-1:0]         cfg_index     = REG_THRESHOLD;
	logic [CFG_W-1:0]             cfg_wdata     = '0;
	logic                         busy;
	logic                         done;
	logic                         hit;
	logic                         boxes_overlap;

	// Words waiting to be driven, and the verdicts the block still owes us.
	cmd_word_t pending_words[$];
	verdict_t  verdicts_due[$];

	int issued_words   = 0;
	int accepted_words = 0;
	int quiet_cycles   = 0;
	int mismatch_count = 0;
	int sender_idle_pct = 16;

	// Shadow copy of the block: both alpha masks and the configuration as
	// the block interprets it (threshold sign-extended, sizes saturated).
	logic [ALPHA_W-1:0] shadow_a [MASK_DEPTH];
	logic [ALPHA_W-1:0] shadow_b [MASK_DEPTH];
	int thr_model = 1;
	int wa_model  = SPRITE_DIM;
	int ha_model  = SPRITE_DIM;
	int wb_model  = SPRITE_DIM;
	int hb_model  = SPRITE_DIM;

	sprite_pixel_collision #(
		.SPRITE_DIM(SPRITE_DIM),
		.COORD_BITS(COORD_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.sprite_sel(sprite_sel),
		.pixel_x(pixel_x),
		.pixel_y(pixel_y),
		.alpha(alpha),
		.pos_a_x(pos_a_x),
		.pos_a_y(pos_a_y),
		.pos_b_x(pos_b_x),
		.pos_b_y(pos_b_y),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.done(done),
		.hit(hit),
		.boxes_overlap(boxes_overlap)
	);

	// 8 ns clock: high for 4 ns, then low for 4 ns.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// Appends one word to the end of the list of words to drive.
	function automatic void add_word(input cmd_word_t w);
		pending_words.insert(pending_words.size(), w);
	endfunction

	function automatic int sat_dim(input logic [DIM_REG_W-1:0] v);
		return (v > SPRITE_DIM) ? SPRITE_DIM : int'(v);
	endfunction

	function automatic int clamp_coord(input int v);
		return (v < COORD_MIN) ? COORD_MIN : (v > COORD_MAX) ? COORD_MAX : v;
	endfunction

	function automatic int rand_coord();
		return int'($urandom_range(0, COORD_SPAN - 1)) + COORD_MIN;
	endfunction

	// Applies one accepted word to the shadow state. A mask write updates the
	// shadow mask; a test computes the verdict and queues it.
	function automatic void predict_word(input cmd_word_t w);
		int ax, ay, bx, by, l, r, t, b, x, y, ia, ib;
		verdict_t v;
		if (w.op == OP_WRITE) begin
			if (w.sel == SEL_B)
				shadow_b[int'(w.py) * SPRITE_DIM + int'(w.px)] = w.alpha;
			else
				shadow_a[int'(w.py) * SPRITE_DIM + int'(w.px)] = w.alpha;
			return;
		end
		ax = int'($signed(w.ax));
		ay = int'($signed(w.ay));
		bx = int'($signed(w.bx));
		by = int'($signed(w.by));
		// Intersection of the two boxes, right and bottom edges exclusive.
		l = (ax > bx) ? ax : bx;
		t = (ay > by) ? ay : by;
		r = (ax + wa_model < bx + wb_model) ? ax + wa_model : bx + wb_model;
		b = (ay + ha_model < by + hb_model) ? ay + ha_model : by + hb_model;
		v.overlap = (l < r) && (t < b);
		v.hit = 1'b0;
		if (v.overlap) begin
			if (thr_model < 0) begin
				v.hit = 1'b1;
			end else begin
				for (y = t; y < b && !v.hit; y++) begin
					for (x = l; x < r && !v.hit; x++) begin
						ia = (y - ay) * SPRITE_DIM + (x - ax);
						ib = (y - by) * SPRITE_DIM + (x - bx);
						if (int'(shadow_a[ia]) > thr_model && int'(shadow_b[ib]) > thr_model)
							v.hit = 1'b1;
					end
				end
			end
		end
		verdicts_due.insert(verdicts_due.size(), v);
	endfunction

	// A mask write; the position fields are ignored by the block, so they get noise.
	function automatic cmd_word_t make_write(input logic sel, input int px, input int py,
			input int a);
		cmd_word_t w;
		w.op    = OP_WRITE;
		w.sel   = sel;
		w.px    = PIXEL_W'(px);
		w.py    = PIXEL_W'(py);
		w.alpha = ALPHA_W'(a);
		w.ax    = COORD_BITS'($urandom);
		w.ay    = COORD_BITS'($urandom);
		w.bx    = COORD_BITS'($urandom);
		w.by    = COORD_BITS'($urandom);
		return w;
	endfunction

	// A collision test; the pixel fields are ignored by the block, so they get noise.
	function automatic cmd_word_t make_test(input int ax, input int ay, input int bx,
			input int by);
		cmd_word_t w;
		w.op    = OP_TEST;
		w.sel   = 1'($urandom);
		w.px    = PIXEL_W'($urandom);
		w.py    = PIXEL_W'($urandom);
		w.alpha = ALPHA_W'($urandom);
		w.ax    = COORD_BITS'(ax);
		w.ay    = COORD_BITS'(ay);
		w.bx    = COORD_BITS'(bx);
		w.by    = COORD_BITS'(by);
		return w;
	endfunction

	// Most tests place B close enough to A that the boxes may touch or overlap;
	// the rest are anywhere on the screen. Edge positions show up now and then.
	function automatic cmd_word_t rand_test();
		int ax, ay, bx, by;
		ax = rand_coord();
		ay = rand_coord();
		if ($urandom_range(0, 7) == 0)
			ax = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
		if ($urandom_range(0, 7) == 0)
			ay = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
		if ($urandom_range(0, 9) < 8) begin
			bx = clamp_coord(ax + int'($urandom_range(0, wa_model + wb_model + 2)) - wb_model - 1);
			by = clamp_coord(ay + int'($urandom_range(0, ha_model + hb_model + 2)) - hb_model - 1);
		end else begin
			bx = rand_coord();
			by = rand_coord();
		end
		return make_test(ax, ay, bx, by);
	endfunction

	// Mask writes land mostly inside the current sprite box so they matter to
	// later tests. Alpha favors the extremes and values right at the threshold.
	function automatic cmd_word_t rand_write();
		logic sel;
		int w, h, px, py, a;
		sel = 1'($urandom);
		w = (sel == SEL_B) ? wb_model : wa_model;
		h = (sel == SEL_B) ? hb_model : ha_model;
		if (w > 0 && h > 0 && $urandom_range(0, 3) != 0) begin
			px = $urandom_range(0, w - 1);
			py = $urandom_range(0, h - 1);
		end else begin
			px = $urandom_range(0, PIXEL_MAX);
			py = $urandom_range(0, PIXEL_MAX);
		end
		case ($urandom_range(0, 3))
			0: a = 0;
			1: a = ALPHA_MAX;
			2: a = (thr_model >= 0 && thr_model < ALPHA_MAX) ?
				thr_model + int'($urandom_range(0, 1)) : int'($urandom_range(0, ALPHA_MAX));
			default: a = $urandom_range(0, ALPHA_MAX);
		endcase
		return make_write(sel, px, py, a);
	endfunction

	// Blocks until every queued word has been taken and every verdict has come
	// back, then lets the back end finish any trailing mask writes.
	task automatic wait_quiet();
		while (pending_words.size() != 0 || accepted_words != issued_words ||
				verdicts_due.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Writes all five registers plus one unused index. Size registers get
	// random upper data bits, which the block must drop.
	task automatic program_regs(input int thr, input int wa, input int ha, input int wb,
			input int hb);
		logic [CFG_IDX_W-1:0] widx [6];
		logic [CFG_W-1:0]     wdata [6];
		widx[0]  = REG_THRESHOLD;
		widx[1]  = REG_WIDTH_A;
		widx[2]  = REG_HEIGHT_A;
		widx[3]  = REG_WIDTH_B;
		widx[4]  = REG_HEIGHT_B;
		widx[5]  = CFG_IDX_W'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI));
		wdata[0] = CFG_W'(thr);
		wdata[1] = CFG_W'(($urandom_range(0, 3) << DIM_REG_W) | wa);
		wdata[2] = CFG_W'(($urandom_range(0, 3) << DIM_REG_W) | ha);
		wdata[3] = CFG_W'(($urandom_range(0, 3) << DIM_REG_W) | wb);
		wdata[4] = CFG_W'(($urandom_range(0, 3) << DIM_REG_W) | hb);
		wdata[5] = CFG_W'($urandom);
		for (int i = 0; i < 6; i++) begin
			@(negedge clk);
			cfg_we    <= 1'b1;
			cfg_index <= widx[i];
			cfg_wdata <= wdata[i];
			case (widx[i])
				REG_THRESHOLD: thr_model = int'($signed(wdata[i]));
				REG_WIDTH_A:   wa_model  = sat_dim(wdata[i][DIM_REG_W-1:0]);
				REG_HEIGHT_A:  ha_model  = sat_dim(wdata[i][DIM_REG_W-1:0]);
				REG_WIDTH_B:   wb_model  = sat_dim(wdata[i][DIM_REG_W-1:0]);
				REG_HEIGHT_B:  hb_model  = sat_dim(wdata[i][DIM_REG_W-1:0]);
				default: ;
			endcase
		end
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Driver. On each falling edge it either holds the current word (start is
	// high and the block has not taken it yet) or moves on: it presents the next
	// pending word, unless the queue is empty or the random idle roll says to
	// leave a gap. start gets at most one assignment per edge, so back-to-back
	// words keep it high without a glitch.
	always @(negedge clk) begin : drive_words
		cmd_word_t w;
		if (!(start && accepted_words < issued_words)) begin
			if (pending_words.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
				w = pending_words.pop_front();
				operation  <= w.op;
				sprite_sel <= w.sel;
				pixel_x    <= w.px;
				pixel_y    <= w.py;
				alpha      <= w.alpha;
				pos_a_x    <= w.ax;
				pos_a_y    <= w.ay;
				pos_b_x    <= w.bx;
				pos_b_y    <= w.by;
				issued_words++;
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor. On each rising edge it first checks a result word against the
	// oldest owed verdict, then records an accepted command word and feeds it
	// to the shadow model. A result can never belong to a word taken on the
	// same edge, so this order is safe. The watchdog counts edges on which
	// nothing moved in either direction.
	always @(posedge clk) begin : watch_results
		verdict_t  due;
		cmd_word_t w;
		if (arst_n) begin
			quiet_cycles++;
			if (done) begin
				quiet_cycles = 0;
				if (verdicts_due.size() == 0) begin
					report_mismatch($sformatf("result word with no test pending: hit=%0b overlap=%0b",
						hit, boxes_overlap));
				end else begin
					due = verdicts_due.pop_front();
					if (hit !== due.hit)
						report_mismatch($sformatf("hit is %0b, expected %0b", hit, due.hit));
					if (boxes_overlap !== due.overlap)
						report_mismatch($sformatf("boxes_overlap is %0b, expected %0b",
							boxes_overlap, due.overlap));
				end
			end
			if (start && !busy) begin
				quiet_cycles = 0;
				accepted_words++;
				w.op    = operation;
				w.sel   = sprite_sel;
				w.px    = pixel_x;
				w.py    = pixel_y;
				w.alpha = alpha;
				w.ax    = pos_a_x;
				w.ay    = pos_a_y;
				w.bx    = pos_b_x;
				w.by    = pos_b_y;
				predict_word(w);
			end
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// Stimulus sequence.
	initial begin : run_sequence
		int thr, wa, ha, wb, hb;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		// Mask contents are undefined after reset. Scans only ever visit the
		// top-left FILL_DIM by FILL_DIM corner of each mask or pixels written
		// just before, so that corner is filled first. The fill is mostly
		// transparent with a sprinkling of random alpha.
		for (int s = 0; s < 2; s++)
			for (int y = 0; y < FILL_DIM; y++)
				for (int x = 0; x < FILL_DIM; x++)
					add_word(make_write(s ? SEL_B : SEL_A, x, y,
						($urandom_range(0, 3) == 0) ? $urandom_range(0, ALPHA_MAX) : 0));

		// Directed tests at the reset configuration: threshold 1, 64 by 64.
		// The far corners of the masks and the extremes of alpha come first.
		add_word(make_write(SEL_A, 0, 0, 0));
		add_word(make_write(SEL_A, PIXEL_MAX, PIXEL_MAX, ALPHA_MAX));
		add_word(make_write(SEL_B, 0, 0, ALPHA_MAX));
		add_word(make_write(SEL_B, PIXEL_MAX, PIXEL_MAX, 0));
		// A one-pixel overlap where A's last pixel meets B's first: a hit.
		add_word(make_test(0, 0, SPRITE_DIM - 1, SPRITE_DIM - 1));
		// Alpha equal to the threshold does not exceed it: overlap but no hit.
		add_word(make_write(SEL_A, PIXEL_MAX, PIXEL_MAX, 1));
		add_word(make_test(0, 0, SPRITE_DIM - 1, SPRITE_DIM - 1));
		// Boxes that only share an edge do not overlap.
		add_word(make_test(0, 0, SPRITE_DIM, 0));
		add_word(make_test(0, 0, 0, SPRITE_DIM));
		// One-pixel overlap at A's first pixel, which is transparent.
		add_word(make_test(-1, -1, -SPRITE_DIM, -SPRITE_DIM));

		// Zero width: the box is empty, so even the box-only mode reports nothing.
		wait_quiet();
		program_regs(-1, 0, SPRITE_DIM, SPRITE_DIM, SPRITE_DIM);
		add_word(make_test(0, 0, 0, 0));
		add_word(make_test(5, 5, 0, 0));

		// Oversized width saturates to the mask size; negative threshold means
		// box overlap alone is a hit.
		wait_quiet();
		program_regs(-1, 127, SPRITE_DIM, SPRITE_DIM, SPRITE_DIM);
		add_word(make_test(0, 0, SPRITE_DIM - 1, 0));
		// Screen extremes in box-only mode, including boxes that reach past the
		// coordinate range.
		add_word(make_test(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
		add_word(make_test(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
		add_word(make_test(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX));
		add_word(make_test(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX));

		// Threshold 255: no alpha can exceed it, even fully opaque pixels.
		wait_quiet();
		program_regs(ALPHA_MAX, FILL_DIM, FILL_DIM, FILL_DIM, FILL_DIM);
		add_word(make_write(SEL_A, 0, 0, ALPHA_MAX));
		add_word(make_write(SEL_B, 0, 0, ALPHA_MAX));
		add_word(make_test(0, 0, 0, 0));

		// One below: the same opaque pair now collides.
		wait_quiet();
		program_regs(ALPHA_MAX - 1, FILL_DIM, FILL_DIM, FILL_DIM, FILL_DIM);
		add_word(make_test(0, 0, 0, 0));

		// Random phases. Each phase picks a configuration. Sprites stay inside
		// the filled corner whenever the threshold lets a test scan; full-size
		// sprites only show up in box-only mode. Halfway through every phase
		// the sender holds off until all verdicts are in.
		for (int p = 0; p < PHASES; p++) begin
			sender_idle_pct = (p < 4) ? 16 : (p < 7) ? 76 : 0;
			thr = $urandom_range(0, ALPHA_MAX);
			wa  = $urandom_range(1, FILL_DIM);
			ha  = $urandom_range(1, FILL_DIM);
			wb  = $urandom_range(1, FILL_DIM);
			hb  = $urandom_range(1, FILL_DIM);
			case (p)
				0: thr = 0;
				1: thr = 1;
				2: begin
					thr = COORD_MIN >>> 2;
					hb  = 0;
				end
				3: thr = 128;
				4: thr = ALPHA_MAX - 1;
				5: begin
					thr = -1;
					wa  = 100;
				end
				6: thr = ALPHA_MAX;
				7: thr = int'($signed(CFG_W'($urandom)));
				8: begin
					thr = 0;
					wa  = 1;
					ha  = 1;
					wb  = 1;
					hb  = 1;
				end
				default: begin
					thr = -ALPHA_MAX;
					wa  = SPRITE_DIM;
					ha  = SPRITE_DIM;
					wb  = SPRITE_DIM;
					hb  = SPRITE_DIM;
				end
			endcase
			wait_quiet();
			program_regs(thr, wa, ha, wb, hb);
			for (int n = 0; n < WORDS_PER_PHASE; n++) begin
				if (n == WORDS_PER_PHASE / 2)
					wait_quiet();
				if ($urandom_range(0, 9) < 4)
					add_word(rand_write());
				else
					add_word(rand_test());
			end
		end

		// Everything sent: wait for the last verdicts and a short drain.
		wait_quiet();
		if (mismatch_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
